>>> hw/rtl/stic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stic_pkg
// Shared types and constants for the segment table insert/cast-out block.
// ----------------------------------------------------------------------------
package stic_pkg;

  localparam int WAYS      = 8;
  localparam int GROUPS    = 32;
  localparam int LOG_DEPTH = 8;

  localparam int TOTAL  = GROUPS * WAYS;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int GRP_W  = $clog2(GROUPS);
  localparam int SLOT_W = WAY_W + GRP_W;
  localparam int PTR_W  = WAY_W + 1;
  localparam int LOG_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LCNT_W = $clog2(LOG_DEPTH + 2);
  localparam int ESID_W = 36;
  localparam int VSID_W = 52;

  localparam logic [ESID_W-1:0] KBASE_RESET = 36'hC_0000_0000;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ESID_W-1:0] esid;
    logic [VSID_W-1:0] vsid;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        slot_index;
    logic              cast_out;
    logic [ESID_W-1:0] victim_esid;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic dispatch;
    logic scan;
    logic vreq;
    logic vchk;
    logic write;
    logic log_step;
    logic log_end;
    logic sreq;
    logic schk;
  } dp_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic ovf;
    logic free_any;
    logic vdone;
    logic log_more;
    logic sweep_last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/stic_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stic_ctrl
// Sequencer for insert search, victim walk, log flush and overflow sweep.
// ----------------------------------------------------------------------------
module stic_ctrl
  import stic_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output logic          done,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_VREQ = 4'd3;
  localparam logic [3:0] S_VCHK = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_LOG  = 4'd6;
  localparam logic [3:0] S_SREQ = 4'd7;
  localparam logic [3:0] S_SCHK = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        if (!stat.is_flush) state_nxt = S_SCAN;
        else if (stat.ovf)  state_nxt = S_SREQ;
        else                state_nxt = S_LOG;
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = stat.free_any ? S_WR : S_VREQ;
      end
      S_VREQ: begin
        cmd.vreq  = 1'b1;
        state_nxt = S_VCHK;
      end
      S_VCHK: begin
        cmd.vchk  = 1'b1;
        state_nxt = stat.vdone ? S_WR : S_VREQ;
      end
      S_WR: begin
        cmd.write = 1'b1;
        state_nxt = S_DONE;
      end
      S_LOG: begin
        if (stat.log_more) begin
          cmd.log_step = 1'b1;
        end else begin
          cmd.log_end = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_SREQ: begin
        cmd.sreq  = 1'b1;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        cmd.schk = 1'b1;
        if (stat.sweep_last) begin
          cmd.log_end = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_SREQ;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

`default_nettype wire

>>> hw/rtl/stic_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stic_dp
// Table storage, valid bits, victim pointer, user log and result registers.
// ----------------------------------------------------------------------------
module stic_dp
  import stic_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire in_word_t          in_data,
  input  wire logic              cfg_we,
  input  wire logic [ESID_W-1:0] cfg_data,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  output out_word_t              out_data
);

  // tag memory holds {user flag, esid}; valid lives in flops
  logic [ESID_W:0]        tag_mem [TOTAL];
  logic [VSID_W-1:0]      xlt_mem [TOTAL];
  logic [TOTAL-1:0]       valid_r;
  logic [ESID_W:0]        rd_q_r;
  logic [SLOT_W-1:0]      rd_addr;

  logic [ESID_W-1:0]      kbase_r;
  logic                   cmd_r;
  logic [ESID_W-1:0]      esid_r;
  logic [VSID_W-1:0]      vsid_r;
  logic [PTR_W-1:0]       vptr_r, p_r, cnt_r;
  logic [SLOT_W-1:0]      slot_r;
  logic                   castout_r;
  logic [ESID_W-1:0]      old_r;
  logic [SLOT_W-1:0]      idx_r;
  logic [SLOT_W-1:0]      log_r [LOG_DEPTH];
  logic [LCNT_W-1:0]      lcnt_r;

  logic [GRP_W-1:0]       pg, sg;
  logic [2*WAYS-1:0]      free;
  logic [PTR_W-1:0]       first_free, fp;
  logic                   vmatch, vlast, user;
  logic [ESID_W-1:0]      rd_esid;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [GRP_W-1:0] a,
                                                input logic [GRP_W-1:0] b,
                                                input logic [PTR_W-1:0] p);
    slot_of = {(p[PTR_W-1] ? b : a), p[WAY_W-1:0]};
  endfunction

  assign pg      = esid_r[GRP_W-1:0];
  assign sg      = ~pg;
  assign rd_esid = rd_q_r[ESID_W-1:0];
  assign user    = (esid_r < kbase_r);
  assign vmatch  = (rd_esid == kbase_r);
  assign vlast   = (cnt_r == PTR_W'(2*WAYS-1));
  assign fp      = vmatch ? p_r + 1'b1 : p_r;

  always_comb begin
    first_free = '0;
    for (int i = 2*WAYS-1; i >= 0; i--) begin
      free[i] = ~valid_r[slot_of(pg, sg, PTR_W'(i))];
      if (free[i]) first_free = PTR_W'(i);
    end
  end

  assign rd_addr = cmd.sreq ? idx_r : slot_of(pg, sg, p_r);

  always_ff @(posedge clk) begin
    if (cmd.vreq || cmd.sreq) rd_q_r <= tag_mem[rd_addr];
    if (cmd.write) begin
      tag_mem[slot_r] <= {user, esid_r};
      xlt_mem[slot_r] <= vsid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r <= KBASE_RESET;
      valid_r <= '0;
      vptr_r  <= '0;
      lcnt_r  <= '0;
    end else begin
      if (cfg_we) kbase_r <= cfg_data;
      if (cmd.vchk && !(vmatch && !vlast)) vptr_r <= fp + 1'b1;
      if (cmd.write) begin
        valid_r[slot_r] <= 1'b1;
        if (user) begin
          if (lcnt_r < LCNT_W'(LOG_DEPTH)) begin
            log_r[lcnt_r[LOG_W-1:0]] <= slot_r;
            lcnt_r <= lcnt_r + 1'b1;
          end else begin
            lcnt_r <= LCNT_W'(LOG_DEPTH + 1);
          end
        end
      end
      if (cmd.log_step) valid_r[log_r[idx_r[LOG_W-1:0]]] <= 1'b0;
      if (cmd.schk && valid_r[idx_r] && (rd_esid < kbase_r)) valid_r[idx_r] <= 1'b0;
      if (cmd.log_end) lcnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_data.command;
      esid_r <= in_data.esid;
      vsid_r <= in_data.vsid;
    end
    if (cmd.dispatch) begin
      slot_r    <= '0;
      castout_r <= 1'b0;
      old_r     <= '0;
      idx_r     <= (lcnt_r > LCNT_W'(LOG_DEPTH)) ? SLOT_W'(1) : '0;
    end
    if (cmd.scan) begin
      p_r   <= vptr_r;
      cnt_r <= '0;
      if (|free) slot_r <= slot_of(pg, sg, first_free);
    end
    if (cmd.vchk) begin
      if (vmatch && !vlast) begin
        p_r   <= p_r + 1'b1;
        cnt_r <= cnt_r + 1'b1;
      end else begin
        slot_r    <= slot_of(pg, sg, fp);
        castout_r <= 1'b1;
        old_r     <= rd_esid;
      end
    end
    if (cmd.log_step || cmd.schk) idx_r <= idx_r + 1'b1;
  end

  assign stat.is_flush   = (cmd_r == CMD_FLUSH);
  assign stat.ovf        = (lcnt_r > LCNT_W'(LOG_DEPTH));
  assign stat.free_any   = |free;
  assign stat.vdone      = !(vmatch && !vlast);
  assign stat.log_more   = ({{(SLOT_W){1'b0}}, lcnt_r} > {{(LCNT_W){1'b0}}, idx_r});
  assign stat.sweep_last = (idx_r == SLOT_W'(TOTAL-1));

  assign out_data.slot_index  = 8'(slot_r);
  assign out_data.cast_out    = castout_r;
  assign out_data.victim_esid = old_r;

endmodule

`default_nettype wire

>>> hw/rtl/segment_table_insert_castout.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_table_insert_castout
// Two-group hashed segment table with round-robin cast-out and user flush.
// ----------------------------------------------------------------------------
// Insert: a free slot is written directly when one exists; otherwise the victim
//   walk reads the tag memory (one read per request/check pair, 16 slots max).
// Flush: clears the logged entries, or sweeps the tag memory on log overflow.
// One word in flight; out_valid pulses in the last busy cycle, cannot be stalled,
//   and the next word can be taken in the cycle after it.
// Reset clears valid bits, victim pointer and log count; no clearing pass.
module segment_table_insert_castout
  import stic_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  output out_word_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [ESID_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  stic_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .cmd   (cmd),
    .stat  (stat)
  );

  stic_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy window");

  a_old_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.cast_out) |-> (out_data.victim_esid == '0))
    else $error("victim esid without cast-out");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("accept did not start");

endmodule

`default_nettype wire
